[sv/hpc_pkg.sv]
`timescale 1ns / 1ps

package hpc_pkg;

  // Field and register widths.
  localparam int COORD_WIDTH = 32;
  localparam int SIDE_W      = 31;
  localparam int INV_W       = 25;
  localparam int OUT_W       = 17;
  localparam int CFG_DATA_W  = 31;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SIDE_LENGTH     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INV_SIDE_LENGTH = CFG_IDX_W'(1);

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(65536);
  localparam logic [INV_W-1:0]  INV_RESET  = INV_W'(16777216);

  // Constants in Q.24.
  localparam int CONST_W = 24;
  localparam int FRAC    = 24;
  localparam logic [CONST_W-1:0] K_HALF_SQRT3  = CONST_W'(14529495);
  localparam logic [CONST_W-1:0] C_TWO_THIRDS  = CONST_W'(11184811);
  localparam logic [CONST_W-1:0] C_ONE_THIRD   = CONST_W'(5592405);
  localparam logic [CONST_W-1:0] C_SQRT3_THIRD = CONST_W'(9686330);
  localparam logic signed [CONST_W:0] C23_S = $signed({1'b0, C_TWO_THIRDS});
  localparam logic signed [CONST_W:0] C13_S = $signed({1'b0, C_ONE_THIRD});
  localparam logic signed [CONST_W:0] C33_S = $signed({1'b0, C_SQRT3_THIRD});

  // Front datapath widths.
  localparam int TX_W        = ((COORD_WIDTH > 34) ? COORD_WIDTH : 34) + 2;
  localparam int TY_W        = ((COORD_WIDTH > 32) ? COORD_WIDTH : 32) + 2;
  localparam int HPROD_W     = SIDE_W + CONST_W;
  localparam int HH_SHIFT    = 23;
  localparam int HH_W        = HPROD_W - HH_SHIFT;
  localparam logic [HPROD_W-1:0] HH_ROUND = HPROD_W'(1) << (HH_SHIFT - 1);
  localparam int AXIAL_SHIFT = 17;
  localparam int PX_W        = TX_W + CONST_W + 1;
  localparam int PY_W        = TY_W + CONST_W + 1;
  localparam int AXL_W       = TX_W + 9;

  // Back datapath widths.
  localparam int LO_W  = 22;
  localparam int HI_W  = AXL_W - LO_W;
  localparam int PL_W  = LO_W + INV_W;
  localparam int PH_W  = HI_W + INV_W + 1;
  localparam int S_W   = AXL_W + INV_W + 1;
  localparam int Q_W   = AXL_W + 1;
  localparam int CY_W  = Q_W + 1;
  localparam int MAG_W = CY_W;
  localparam int KM_W  = MAG_W - FRAC + 1;
  localparam int K_W   = KM_W + 1;
  localparam int ERR_W = FRAC;
  localparam int K2_W  = K_W + 1;
  localparam int ROW_W = K2_W + 1;

  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};

  // Pipeline and queue shape.
  localparam int FRONT_STAGES = 3;
  localparam int FCNT_W       = $clog2(FRONT_STAGES + 1);
  localparam int BACK_STAGES  = 6;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);
  localparam int LATENCY      = FRONT_STAGES + 1 + BACK_STAGES;

  typedef struct packed {
    logic signed [AXL_W-1:0] ax;
    logic signed [AXL_W-1:0] az;
  } axial_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } queue_stat_t;

  function automatic logic [OUT_W-1:0] sat_out(input logic signed [ROW_W-1:0] v);
    logic [ROW_W-OUT_W:0] upper;
    logic [OUT_W-1:0]     res;
    upper = v[ROW_W-1:OUT_W-1];
    priority if (upper == '0 || upper == '1) begin
      res = v[OUT_W-1:0];
    end else if (v[ROW_W-1]) begin
      res = OUT_MIN;
    end else begin
      res = OUT_MAX;
    end
    return res;
  endfunction

endpackage

[sv/hpc_front.sv]
`timescale 1ns / 1ps

module hpc_front import hpc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic [SIDE_W-1:0]             side_length_i,
  output logic                          push_o,
  output axial_t                        axial_o,
  output logic [FCNT_W-1:0]             inflight_o
);

  logic [FRONT_STAGES-1:0] fv_q;

  // Stage 1: shifted x and the half-height product.
  logic signed [TX_W-1:0]        x_ext;
  logic [TX_W-1:0]               s5;
  logic signed [TX_W-1:0]        tx1_d, tx1_q;
  logic [HPROD_W-1:0]            hprod_d, hprod_q;
  logic signed [COORD_WIDTH-1:0] y1_q;

  // Stage 2: shifted y and the x products.
  logic [HPROD_W-1:0]     hh_sum;
  logic [HH_W-1:0]        hh;
  logic signed [TY_W-1:0] ty2_d, ty2_q;
  logic signed [PX_W-1:0] p23_d, p23_q, p13_d, p13_q;

  // Stage 3: axial q and the y product.
  logic signed [AXL_W-1:0] ax3_d, ax3_q, m13_d, m13_q;
  logic signed [PY_W-1:0]  pty_d, pty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else begin
      fv_q <= {fv_q[FRONT_STAGES-2:0], accept_i};
    end
  end

  assign x_ext   = TX_W'(point_x_i);
  assign s5      = TX_W'({side_length_i, 2'b00}) + TX_W'(side_length_i);
  assign tx1_d   = (x_ext <<< 1) - $signed(s5);
  assign hprod_d = HPROD_W'(side_length_i) * HPROD_W'(K_HALF_SQRT3);

  assign hh_sum = hprod_q + HH_ROUND;
  assign hh     = hh_sum[HPROD_W-1:HH_SHIFT];
  assign ty2_d  = (TY_W'(y1_q) <<< 1) - $signed(TY_W'(hh));
  assign p23_d  = PX_W'(tx1_q) * PX_W'(C23_S);
  assign p13_d  = PX_W'(tx1_q) * PX_W'(C13_S);

  assign ax3_d = AXL_W'(p23_q >>> AXIAL_SHIFT);
  assign m13_d = AXL_W'(p13_q >>> AXIAL_SHIFT);
  assign pty_d = PY_W'(ty2_q) * PY_W'(C33_S);

  always_ff @(posedge clk_i) begin
    tx1_q   <= tx1_d;
    hprod_q <= hprod_d;
    y1_q    <= point_y_i;
    ty2_q   <= ty2_d;
    p23_q   <= p23_d;
    p13_q   <= p13_d;
    ax3_q   <= ax3_d;
    m13_q   <= m13_d;
    pty_q   <= pty_d;
  end

  assign push_o     = fv_q[FRONT_STAGES-1];
  assign axial_o.ax = ax3_q;
  assign axial_o.az = AXL_W'(pty_q >>> AXIAL_SHIFT) - m13_q;
  assign inflight_o = FCNT_W'($countones(fv_q));

endmodule

[sv/hpc_queue.sv]
`timescale 1ns / 1ps

module hpc_queue import hpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  axial_t      data_i,
  input  logic        pop_i,
  output axial_t      data_o,
  output queue_stat_t stat_o
);

  axial_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + QCNT_W'(1);
      2'b01:   count_d = count_q - QCNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.empty = (count_q == '0);

endmodule

[sv/hpc_back.sv]
`timescale 1ns / 1ps

module hpc_back import hpc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  axial_t                  axial_i,
  input  logic [INV_W-1:0]        inv_side_length_i,
  output logic                    done_o,
  output logic signed [OUT_W-1:0] cell_column_o,
  output logic signed [OUT_W-1:0] cell_row_o
);

  // Lane order for the three cube components.
  localparam int LX = 0;
  localparam int LY = 1;
  localparam int LZ = 2;

  logic [BACK_STAGES-1:0] bv_q;

  // Stage 1: partial products of the scaling.
  logic [PL_W-1:0]        plq_q, plr_q;
  logic signed [PH_W-1:0] phq_q, phr_q;
  logic signed [INV_W:0]  inv_s;

  // Stage 2: scaled q and r.
  logic signed [S_W-1:0] sum_q, sum_r;
  logic signed [Q_W-1:0] q_q, r_q;

  // Stages 3 to 5, one lane per cube component.
  logic signed [CY_W-1:0]  v_d [3];
  logic signed [CY_W-1:0]  v_q [3];
  logic [MAG_W-1:0]        mag_q [3];
  logic                    neg_q [3];
  logic signed [K_W-1:0]   k_q [3];
  logic [ERR_W-1:0]        err_q [3];

  // Stage 6: selection, rebuild and offset conversion.
  logic signed [K2_W-1:0]  ex, ey, ez, kx_f, kz_f;
  logic signed [ROW_W-1:0] row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= '0;
    end else begin
      bv_q <= {bv_q[BACK_STAGES-2:0], valid_i};
    end
  end

  assign inv_s = $signed({1'b0, inv_side_length_i});

  always_ff @(posedge clk_i) begin
    plq_q <= PL_W'(axial_i.ax[LO_W-1:0]) * PL_W'(inv_side_length_i);
    plr_q <= PL_W'(axial_i.az[LO_W-1:0]) * PL_W'(inv_side_length_i);
    phq_q <= PH_W'($signed(axial_i.ax[AXL_W-1:LO_W])) * PH_W'(inv_s);
    phr_q <= PH_W'($signed(axial_i.az[AXL_W-1:LO_W])) * PH_W'(inv_s);
  end

  // The arithmetic shift of the exact product is the floor the format needs.
  assign sum_q = (S_W'(phq_q) <<< LO_W) + $signed(S_W'(plq_q));
  assign sum_r = (S_W'(phr_q) <<< LO_W) + $signed(S_W'(plr_q));

  always_ff @(posedge clk_i) begin
    q_q <= Q_W'(sum_q >>> FRAC);
    r_q <= Q_W'(sum_r >>> FRAC);
  end

  always_comb begin
    v_d[LX] = CY_W'(q_q);
    v_d[LY] = -CY_W'(q_q) - CY_W'(r_q);
    v_d[LZ] = CY_W'(r_q);
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    logic [KM_W-1:0]  kmag;
    logic [ERR_W-1:0] err;

    // Rounding half away from zero works on the magnitude; bit FRAC-1 says
    // whether the fraction reaches one half.
    assign kmag = KM_W'(mag_q[g][MAG_W-1:FRAC]) + KM_W'(mag_q[g][FRAC-1]);
    assign err  = mag_q[g][FRAC-1]
                ? ERR_W'({1'b1, {FRAC{1'b0}}} - {1'b0, mag_q[g][FRAC-1:0]})
                : mag_q[g][FRAC-1:0];

    always_ff @(posedge clk_i) begin
      v_q[g]   <= v_d[g];
      neg_q[g] <= v_q[g][CY_W-1];
      mag_q[g] <= v_q[g][CY_W-1] ? MAG_W'(-v_q[g]) : MAG_W'(v_q[g]);
      k_q[g]   <= neg_q[g] ? -$signed(K_W'(kmag)) : $signed(K_W'(kmag));
      err_q[g] <= err;
    end
  end

  always_comb begin
    ex   = K2_W'(k_q[LX]);
    ey   = K2_W'(k_q[LY]);
    ez   = K2_W'(k_q[LZ]);
    kx_f = ex;
    kz_f = ez;
    // The strictly largest error is rebuilt; ties go to z, x/y ties to y.
    priority if (err_q[LX] > err_q[LY] && err_q[LX] > err_q[LZ]) begin
      kx_f = -ey - ez;
    end else if (err_q[LY] > err_q[LZ]) begin
      kx_f = ex;
    end else begin
      kz_f = -ex - ey;
    end
    row = ROW_W'(kz_f) + ROW_W'(kx_f >>> 1);
  end

  always_ff @(posedge clk_i) begin
    cell_column_o <= sat_out(ROW_W'(kx_f));
    cell_row_o    <= sat_out(row);
  end

  assign done_o = bv_q[BACK_STAGES-1];

endmodule

[sv/hex_point_to_cell.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// point     in         start_i, busy_o        point_x_i, point_y_i
// cell      out        done_o (one cycle)     cell_column_o, cell_row_o
// config    in         cfg_we_i               cfg_index_i, cfg_data_i
//
// One point is taken every cycle while busy_o is low; each cell word leaves after its
// point has passed three front stages, the axial queue and six back stages
// for scaling, rounding and offset conversion.
// Reset clears the pipeline valid bits, the queue pointers and sets the side
// length and its reciprocal to 1.0. The receiver cannot stall; busy_o rises
// only if the axial queue together with the front stages could overflow.

module hex_point_to_cell import hpc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  output logic                          done_o,
  output logic signed [OUT_W-1:0]       cell_column_o,
  output logic signed [OUT_W-1:0]       cell_row_o
);

  localparam int OCC_W = QCNT_W + 1;

  logic [SIDE_W-1:0]  side_q;
  logic [INV_W-1:0]   inv_q;
  logic               accept;
  logic               push;
  logic               pop;
  axial_t             push_word;
  axial_t             pop_word;
  logic [FCNT_W-1:0]  inflight;
  queue_stat_t        qstat;
  logic [OCC_W-1:0]   occupancy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SIDE_RESET;
      inv_q  <= INV_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SIDE_LENGTH:     side_q <= cfg_data_i[SIDE_W-1:0];
        REG_INV_SIDE_LENGTH: inv_q  <= cfg_data_i[INV_W-1:0];
      endcase
    end
  end

  assign accept = start_i && !busy_o;

  // The back end drains a word every cycle while the queue is not empty, so count
  // what stays after the pending pop plus what the front stages still hold.
  assign pop       = !qstat.empty;
  assign occupancy = OCC_W'(qstat.count) + OCC_W'(inflight) - OCC_W'(pop);
  assign busy_o    = (occupancy >= OCC_W'(QDEPTH));

  hpc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .side_length_i (side_q),
    .push_o        (push),
    .axial_o       (push_word),
    .inflight_o    (inflight)
  );

  hpc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_word),
    .pop_i  (pop),
    .data_o (pop_word),
    .stat_o (qstat)
  );

  hpc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (pop),
    .axial_i           (pop_word),
    .inv_side_length_i (inv_q),
    .done_o            (done_o),
    .cell_column_o     (cell_column_o),
    .cell_row_o        (cell_row_o)
  );

endmodule

[sv/hpc_checker.sv]
`timescale 1ns / 1ps

module hpc_checker import hpc_pkg::*; (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic signed [COORD_WIDTH-1:0] point_x_i,
  input logic signed [COORD_WIDTH-1:0] point_y_i,
  input logic                          cfg_we_i,
  input logic [CFG_IDX_W-1:0]          cfg_index_i,
  input logic [CFG_DATA_W-1:0]         cfg_data_i,
  input logic                          done_o,
  input logic signed [OUT_W-1:0]       cell_column_o,
  input logic signed [OUT_W-1:0]       cell_row_o
);

  // The back end never stalls, so the point side must always be open.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("point port reported busy");

  a_item_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("accepted point produced no cell word");

  a_word_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("cell word without an accepted point");

endmodule

bind hex_point_to_cell hpc_checker u_hpc_checker (.*);

[sim/tb_hex_point_to_cell.sv]
`timescale 1ns / 1ps

module tb_hex_point_to_cell;
  import hpc_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] column;
    logic signed [OUT_W-1:0] row;
  } cell_t;

  // Fixed-point constants in Q.24.
  localparam longint HALF_SQRT3_Q24  = 14529495;
  localparam longint TWO_THIRDS_Q24  = 11184811;
  localparam longint ONE_THIRD_Q24   = 5592405;
  localparam longint SQRT3_THIRD_Q24 = 9686330;
  localparam int     PHASE_POINTS    = 180;

  class hex_cell_board;
    logic [SIDE_W-1:0] side;
    logic [INV_W-1:0]  inv;
    cell_t             pending_cells[$];
    int                mismatch_count;

    function new();
      side           = 31'd65536;
      inv            = 25'd16777216;
      mismatch_count = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SIDE_LENGTH:     side = data[SIDE_W-1:0];
        REG_INV_SIDE_LENGTH: inv  = data[INV_W-1:0];
        default: ;
      endcase
    endfunction

    function wide_t round_half_away(wide_t v);
      wide_t m;
      wide_t k;
      m = (v < 0) ? -v : v;
      k = (m + (wide_t'(1) <<< 23)) >>> 24;
      return (v < 0) ? -k : k;
    endfunction

    function wide_t round_error(wide_t k, wide_t v);
      wide_t d;
      d = k * (wide_t'(1) <<< 24) - v;
      return (d < 0) ? -d : d;
    endfunction

    function logic signed [OUT_W-1:0] clamp_out(wide_t v);
      if (v < -65536) return -17'sd65536;
      if (v > 65535) return 17'sd65535;
      return v[OUT_W-1:0];
    endfunction

    function cell_t locate_cell(logic signed [COORD_WIDTH-1:0] px,
                                logic signed [COORD_WIDTH-1:0] py);
      wide_t x, y, s, iv, hh, tx, ty, ax, az, q, r, cy;
      wide_t kx, ky, kz, dx, dy, dz;
      cell_t res;
      x  = px;
      y  = py;
      s  = side;
      iv = inv;
      hh = (s * HALF_SQRT3_Q24 + (wide_t'(1) <<< 22)) >>> 23;
      // Both shifted coordinates carry 17 fractional bits.
      tx = 2 * x - 5 * s;
      ty = 2 * y - hh;
      ax = (tx * TWO_THIRDS_Q24) >>> 17;
      az = ((ty * SQRT3_THIRD_Q24) >>> 17) - ((tx * ONE_THIRD_Q24) >>> 17);
      q  = (ax * iv) >>> 24;
      r  = (az * iv) >>> 24;
      cy = -q - r;
      kx = round_half_away(q);
      ky = round_half_away(cy);
      kz = round_half_away(r);
      dx = round_error(kx, q);
      dy = round_error(ky, cy);
      dz = round_error(kz, r);
      // The strictly largest error is rebuilt; ties fall to z, x/y ties to y.
      if (dx > dy && dx > dz) begin
        kx = -ky - kz;
      end else if (dy > dz) begin
        ky = -kx - kz;
      end else begin
        kz = -kx - ky;
      end
      res.column = clamp_out(kx);
      res.row    = clamp_out(kz + (kx >>> 1));
      return res;
    endfunction

    function void note_point(logic signed [COORD_WIDTH-1:0] px,
                             logic signed [COORD_WIDTH-1:0] py);
      pending_cells.push_back(locate_cell(px, py));
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
    endtask

    task check_cell(logic signed [OUT_W-1:0] column, logic signed [OUT_W-1:0] row);
      cell_t want;
      if (pending_cells.size() == 0) begin
        report_mismatch("cell word with none pending, column", column, 0);
      end else begin
        want = pending_cells.pop_front();
        if (column !== want.column) report_mismatch("cell_column", column, want.column);
        if (row !== want.row) report_mismatch("cell_row", row, want.row);
      end
    endtask
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  logic signed [COORD_WIDTH-1:0] point_x_i;
  logic signed [COORD_WIDTH-1:0] point_y_i;
  logic                          cfg_we_i;
  logic [CFG_IDX_W-1:0]          cfg_index_i;
  logic [CFG_DATA_W-1:0]         cfg_data_i;
  logic                          done_o;
  logic signed [OUT_W-1:0]       cell_column_o;
  logic signed [OUT_W-1:0]       cell_row_o;

  hex_cell_board board;

  hex_point_to_cell dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .done_o        (done_o),
    .cell_column_o (cell_column_o),
    .cell_row_o    (cell_row_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("hex_point_to_cell: mismatch");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_cell(cell_column_o, cell_row_o);
  end

  task automatic send_point(input logic signed [COORD_WIDTH-1:0] px,
                            input logic signed [COORD_WIDTH-1:0] py);
    @(negedge clk_i);
    start_i   <= 1'b1;
    point_x_i <= px;
    point_y_i <= py;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    board.note_point(px, py);
  endtask

  task automatic pause(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  task automatic drain();
    pause(1);
    while (board.pending_cells.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_register(idx, data);
  endtask

  function automatic int random_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] random_coord();
    logic signed [COORD_WIDTH-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      // Quarter-unit grid points make exact rounding ties more likely.
      7, 8:       v = (int'($urandom_range(0, 64)) - 32) * 16384;
      default: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = '0;
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic random_points(input int count);
    for (int i = 0; i < count; i++) begin
      send_point(random_coord(), random_coord());
      // Every word of the first part of each 64 goes back to back.
      if ((i % 64) >= 24) pause(random_gap());
    end
  endtask

  task automatic run_phase(input logic [SIDE_W-1:0] side, input logic [INV_W-1:0] inv);
    drain();
    write_reg(REG_SIDE_LENGTH, CFG_DATA_W'(side));
    write_reg(REG_INV_SIDE_LENGTH, CFG_DATA_W'(inv));
    random_points(PHASE_POINTS);
  endtask

  initial begin
    logic [COORD_WIDTH-1:0] dir_x [14];
    logic [COORD_WIDTH-1:0] dir_y [14];
    logic [SIDE_W-1:0]      side;
    board       = new();
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    point_x_i   = '0;
    point_y_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_SIDE_LENGTH;
    cfg_data_i  = '0;
    // The cell center at reset settings is (163840, 56756): all errors are zero.
    dir_x = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'hFFFF_FFFF, 32'h1, 32'd163840, 32'd229376, 32'd163840, 32'd262144,
              32'd131072, 32'h5555_5555, 32'hAAAA_AAAA};
    dir_y = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'hFFFF_FFFF, 32'h1, 32'd56756, 32'd56756, 32'd113512, 32'd56756,
              32'd85134, 32'hAAAA_AAAA, 32'h5555_5555};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < 14; i++) begin
      send_point(dir_x[i], dir_y[i]);
      if (i % 3 == 2) pause(i % 4);
    end
    random_points(PHASE_POINTS);

    run_phase(31'd131072, 25'd8388608);
    run_phase(31'h7FFF_FFFF, 25'd512);
    run_phase(31'd0, 25'd0);
    run_phase(31'h7FFF_FFFF, 25'h1FF_FFFF);
    run_phase(31'd655360, 25'd1677722);
    side = SIDE_W'($urandom_range(32'd65536, 32'h0100_0000));
    run_phase(side, INV_W'((64'd1 << 40) / side));
    run_phase(31'd65536, 25'd16777216);

    drain();
    repeat (LATENCY + 4) @(posedge clk_i);
    if (board.mismatch_count == 0 && board.pending_cells.size() == 0) begin
      $display("hex_point_to_cell: match");
    end else begin
      $display("hex_point_to_cell: mismatch");
    end
    $finish;
  end

endmodule
